// ===== design/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int ValueWidth = 64;
    localparam int NumDigits  = 20;
    localparam int StepWidth  = $clog2(ValueWidth);
    localparam int CountWidth = 5;

    localparam logic [1:0] SizeShort = 2'd0;
    localparam logic [1:0] SizeInt   = 2'd1;

    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [3:0] CharDigitHigh = 4'h3;   // upper nibble of '0'..'9'

    localparam logic [3:0] DigitAdjustMin = 4'd5;
    localparam logic [3:0] DigitAdjust    = 4'd3;

    localparam logic [StepWidth-1:0]  LastStep  = StepWidth'(ValueWidth - 1);
    localparam logic [CountWidth-1:0] DigitsAll = CountWidth'(NumDigits);

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic [1:0]                   size_mode;
        logic                         force_plus;
    } operand_t;

    typedef struct packed {
        logic [7:0]            out_char;
        logic                  is_last;
        logic [CountWidth-1:0] char_count;
    } result_t;

    // Per-cycle command to every digit cell
    typedef struct packed {
        logic clear;     // zero the digit
        logic convert;   // add-3 adjust and shift one binary bit in
        logic shift;     // take the digit of the lower neighbor
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage

// ===== design/i2da_digit_cell.sv =====
// ----------------------------------------------------------------------------
// i2da_digit_cell
// One BCD digit of the shift-and-add-3 chain; also moves digits upward.
// ----------------------------------------------------------------------------
module i2da_digit_cell
(
    input  logic                clk,
    input  i2da_pkg::cell_ctrl_t ctrl,
    input  logic                bit_in,
    input  logic [3:0]          digit_in,
    output logic                bit_out,
    output logic [3:0]          digit
);
    import i2da_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Adjust the digit so the shift carries correctly into the next cell
    always_comb
    begin
        adj = (digit_reg >= DigitAdjustMin) ? digit_reg + DigitAdjust : digit_reg;
    end

    assign bit_out = adj[3];
    assign digit   = digit_reg;

    // Select the next digit value
    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== design/i2da_cell_chain.sv =====
// ----------------------------------------------------------------------------
// i2da_cell_chain
// Row of digit cells, lowest digit first; the top cell presents its digit.
// ----------------------------------------------------------------------------
module i2da_cell_chain
(
    input  logic                 clk,
    input  i2da_pkg::cell_ctrl_t ctrl,
    input  logic                 bit_in,
    output logic [3:0]           top_digit
);
    import i2da_pkg::*;

    logic [3:0] digits [NumDigits];
    logic       carries [NumDigits];

    // Each cell takes the carry and digit of its lower neighbor
    for (genvar i = 0; i < NumDigits; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            i2da_digit_cell u_cell
            (
                .clk      (clk),
                .ctrl     (ctrl),
                .bit_in   (bit_in),
                .digit_in (4'd0),
                .bit_out  (carries[i]),
                .digit    (digits[i])
            );
        end
        else
        begin : g_rest
            i2da_digit_cell u_cell
            (
                .clk      (clk),
                .ctrl     (ctrl),
                .bit_in   (carries[i-1]),
                .digit_in (digits[i-1]),
                .bit_out  (carries[i]),
                .digit    (digits[i])
            );
        end
    end

    assign top_digit = digits[NumDigits-1];

endmodule

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Prints one signed integer as decimal ASCII, one character per strobe.
// The magnitude is shifted through the digit cell chain, leading zeros are
// dropped, then the sign (if any) and 1 to 20 digits go out one character per
// cycle, each registered onto the strobe.
// A new operand is taken only in idle; busy stays high until the last
// character is out. The receiver cannot stall the character stream.
// Reset: asynchronous, active low; returns to idle with no strobe pending.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  i2da_pkg::operand_t  operand,
    output logic                valid,
    output i2da_pkg::result_t   result
);
    import i2da_pkg::*;

    state_t                  state_reg, state_next;
    logic [ValueWidth-1:0]   mag_reg, mag_next;
    logic [StepWidth-1:0]    step_reg, step_next;
    logic [CountWidth-1:0]   rem_reg, rem_next;
    logic [CountWidth-1:0]   total_reg, total_next;
    logic                    neg_reg, neg_next;
    logic                    sign_reg, sign_next;
    logic                    valid_reg, valid_next;
    result_t                 result_reg, result_next;

    logic                    accept;
    logic                    neg_in;
    logic [ValueWidth-1:0]   mag_in;
    cell_ctrl_t              ctrl;
    logic [3:0]              top_digit;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

    // Cut the operand to its width and take the magnitude
    always_comb
    begin
        case (operand.size_mode)
            SizeShort:
            begin
                neg_in = operand.value[15];
                mag_in = {48'd0, neg_in ? 16'd0 - operand.value[15:0]
                                        : operand.value[15:0]};
            end
            SizeInt:
            begin
                neg_in = operand.value[31];
                mag_in = {32'd0, neg_in ? 32'd0 - operand.value[31:0]
                                        : operand.value[31:0]};
            end
            default:
            begin
                neg_in = operand.value[63];
                mag_in = neg_in ? 64'd0 - operand.value[63:0] : operand.value[63:0];
            end
        endcase
    end

    i2da_cell_chain u_chain
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (mag_reg[ValueWidth-1]),
        .top_digit (top_digit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (step_reg == LastStep)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!((top_digit == 4'd0) && (rem_reg > 5'd1)))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!sign_reg && (rem_reg == 5'd1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        mag_next    = mag_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        total_next  = total_reg;
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        ctrl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next   = mag_in;
                    neg_next   = neg_in;
                    sign_next  = neg_in || operand.force_plus;
                    step_next  = '0;
                    ctrl.clear = 1'b1;
                end
            end
            ST_CONV:
            begin
                // Shift one magnitude bit into the lowest cell
                ctrl.convert = 1'b1;
                mag_next     = {mag_reg[ValueWidth-2:0], 1'b0};
                step_next    = step_reg + 1'b1;
                rem_next     = DigitsAll;
            end
            ST_SKIP:
            begin
                // Drop a leading zero, keep at least one digit
                if ((top_digit == 4'd0) && (rem_reg > 5'd1))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    total_next = rem_reg + CountWidth'(sign_reg);
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                if (sign_reg)
                begin
                    sign_next   = 1'b0;
                    result_next = '{out_char:   neg_reg ? CharMinus : CharPlus,
                                    is_last:    1'b0,
                                    char_count: '0};
                end
                else
                begin
                    ctrl.shift  = 1'b1;
                    rem_next    = rem_reg - 1'b1;
                    result_next = '{out_char:   {CharDigitHigh, top_digit},
                                    is_last:    rem_reg == 5'd1,
                                    char_count: (rem_reg == 5'd1) ? total_reg : '0};
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        total_reg  <= total_next;
        neg_reg    <= neg_next;
        sign_reg   <= sign_next;
        result_reg <= result_next;
    end

endmodule
